// ===== rtl/bdap_pkg.sv =====
// ----------------------------------------------------------------------------
// bdap_pkg
// Shared constants, codes and controller/datapath interface types for the
// alternating pair path search block.
// ----------------------------------------------------------------------------
package bdap_pkg;

  // Field and register widths
  localparam int MAX_NODES_DEF = 6;
  localparam int CMD_W         = 2;
  localparam int IDX_W         = 4;
  localparam int COST_W        = 16;
  localparam int CNT_W         = 4;
  localparam int AWARD_W       = 10;
  localparam int MEMO_W        = 21;
  localparam int PROFIT_W      = 20;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 24;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0]   COUNT_RESET = 4'd1;
  localparam logic [AWARD_W-1:0] AWARD_RESET = 10'd250;

  // Input item commands
  localparam logic [CMD_W-1:0] CMD_LOAD_FWD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_BWD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AWARD   = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_NODE,
    S_ISSUE,
    S_ACC,
    S_WRITE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic init;      // latch live counts, start at the largest subsets
    logic adv_pair;  // step to the next (i, j) candidate
    logic acc;       // fold the read candidate into the running best
    logic write;     // store the running best, clear best and (i, j)
    logic next_l;    // step to the next last-B node
    logic adv_node;  // step to the next (used A, used B) subset pair
    logic out_load;  // hand the root value to the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic terminal;   // no pair can be added to this subset pair
    logic usable;     // candidate A and B nodes are both free
    logic pair_last;  // candidate is the last (i, j)
    logic l_last;     // last-B loop is at its end
    logic root;       // empty subsets, no last node
    logic out_busy;   // output register holds an item not yet taken
  } ctl_stat_t;

endpackage

// ===== rtl/bdap_ram.sv =====
// ----------------------------------------------------------------------------
// bdap_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bdap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bdap_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdap_ctrl
// Sequencer for the subset search: walks subset pairs, last-B nodes and
// candidate pairs, and paces the memo reads and writes of the datapath.
// ----------------------------------------------------------------------------
module bdap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_is_start,
  output logic                in_tready,
  input  bdap_pkg::ctl_stat_t stat,
  output bdap_pkg::ctl_cmd_t  cmd
);

  import bdap_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_is_start) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: state_nxt = S_NODE;
      S_NODE: begin
        state_nxt = stat.terminal ? S_WRITE : S_ISSUE;
      end
      S_ISSUE: begin
        if (stat.usable) begin
          state_nxt = S_ACC;
        end else if (stat.pair_last) begin
          state_nxt = S_WRITE;
        end
      end
      S_ACC: begin
        state_nxt = stat.pair_last ? S_WRITE : S_ISSUE;
      end
      S_WRITE: begin
        if (stat.root) begin
          if (!stat.out_busy) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_NODE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_INIT:  cmd.init = 1'b1;
      S_NODE:  ;
      S_ISSUE: begin
        cmd.adv_pair = !stat.usable && !stat.pair_last;
      end
      S_ACC: begin
        cmd.acc      = 1'b1;
        cmd.adv_pair = !stat.pair_last;
      end
      S_WRITE: begin
        if (stat.root) begin
          cmd.out_load = !stat.out_busy;
        end else begin
          cmd.write    = 1'b1;
          cmd.adv_node = stat.l_last;
          cmd.next_l   = !stat.l_last;
        end
      end
      default: ;
    endcase
  end

  // Input is only taken while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE)
    else $error("input ready outside idle");

  // A start leaves idle at once
  a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && in_tvalid && in_is_start) |=> state_r == S_INIT)
    else $error("start item not taken up");

endmodule

// ===== rtl/bdap_dp.sv =====
// ----------------------------------------------------------------------------
// bdap_dp
// Datapath: configuration registers, cost matrices, memo RAM, loop counters,
// candidate scoring and the output register.
// ----------------------------------------------------------------------------
module bdap_dp #(
  parameter int MAX_NODES = bdap_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bdap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_fire,
  input  logic [bdap_pkg::CMD_W-1:0]       in_cmd,
  input  logic [bdap_pkg::IDX_W-1:0]       in_row,
  input  logic [bdap_pkg::IDX_W-1:0]       in_col,
  input  logic [bdap_pkg::COST_W-1:0]      in_cost,
  input  bdap_pkg::ctl_cmd_t               cmd,
  output bdap_pkg::ctl_stat_t              stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bdap_pkg::PROFIT_W-1:0]    out_profit
);

  import bdap_pkg::*;

  localparam int LW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int COST_AW  = 2 * LW;
  localparam int COST_D   = 1 << COST_AW;
  localparam int MEMO_AW  = 2 * MAX_NODES + LW;
  localparam int MEMO_D   = 1 << MEMO_AW;
  localparam int SW       = MEMO_W + 2;
  localparam int PC_W     = $clog2(MAX_NODES + 1);

  // Configuration and search registers
  logic [CNT_W-1:0]     count_a_r, count_b_r;
  logic [AWARD_W-1:0]   award_r;
  logic [CNT_W-1:0]     la_r, lb_r;
  logic [MAX_NODES-1:0] ua_r, ub_r;
  logic [LW-1:0]        l_r, i_r, j_r;
  logic [MEMO_W-1:0]    best_r;
  logic                 out_valid_r;
  logic [PROFIT_W-1:0]  out_profit_r;

  logic [CNT_W-1:0]     la_clamp, lb_clamp;
  logic [MAX_NODES-1:0] ua_max, ub_max, ub_max_cur;
  logic [MAX_NODES-1:0] ua_succ, ub_succ;
  logic [PC_W-1:0]      pc_a, pc_b;
  logic                 root;

  logic                 fwd_we, bwd_we, load_ok;
  logic [COST_AW-1:0]   load_addr;
  logic [COST_W-1:0]    fwd_rd, bwd_rd;
  logic [MEMO_W-1:0]    memo_rd;
  logic                 memo_we;
  logic signed [SW-1:0] sol;
  logic signed [SW-1:0] bwd_term;

  // Clamp counts to the built capacity
  assign la_clamp = (count_a_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : count_a_r;
  assign lb_clamp = (count_b_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : count_b_r;
  assign ua_max     = ~({MAX_NODES{1'b1}} << la_clamp);
  assign ub_max     = ~({MAX_NODES{1'b1}} << lb_clamp);
  assign ub_max_cur = ~({MAX_NODES{1'b1}} << lb_r);

  // Count used nodes in each subset
  always_comb begin
    pc_a = '0;
    pc_b = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      pc_a = pc_a + PC_W'(ua_r[k]);
      pc_b = pc_b + PC_W'(ub_r[k]);
    end
  end

  assign root    = (ua_r == '0) && (ub_r == '0);
  assign ua_succ = ua_r | (MAX_NODES'(1) << i_r);
  assign ub_succ = ub_r | (MAX_NODES'(1) << j_r);

  // Status to the controller
  always_comb begin
    stat.terminal  = (CNT_W'(pc_a) == la_r) || (CNT_W'(pc_b) == lb_r);
    stat.usable    = !ua_r[i_r] && !ub_r[j_r];
    stat.pair_last = (CNT_W'(i_r) == CNT_W'(la_r - 1'b1)) &&
                     (CNT_W'(j_r) == CNT_W'(lb_r - 1'b1));
    stat.l_last    = root || ((CNT_W + 1)'(l_r) + 1'b1 >= (CNT_W + 1)'(lb_r));
    stat.root      = root;
    stat.out_busy  = out_valid_r && !out_tready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= COUNT_RESET;
      count_b_r <= COUNT_RESET;
      award_r   <= AWARD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT_A: count_a_r <= cfg_wdata[CNT_W-1:0];
        CFG_COUNT_B: count_b_r <= cfg_wdata[CNT_W-1:0];
        CFG_AWARD:   award_r   <= cfg_wdata[AWARD_W-1:0];
        default: ;
      endcase
    end
  end

  // Cost matrix loads
  assign load_ok   = (in_row < IDX_W'(MAX_NODES)) && (in_col < IDX_W'(MAX_NODES));
  assign load_addr = {in_row[LW-1:0], in_col[LW-1:0]};
  assign fwd_we    = in_fire && load_ok && (in_cmd == CMD_LOAD_FWD);
  assign bwd_we    = in_fire && load_ok && (in_cmd == CMD_LOAD_BWD);

  bdap_ram #(.WIDTH(COST_W), .DEPTH(COST_D)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (load_addr),
    .wdata (in_cost),
    .raddr ({i_r, j_r}),
    .rdata (fwd_rd)
  );

  bdap_ram #(.WIDTH(COST_W), .DEPTH(COST_D)) u_bwd_ram (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (load_addr),
    .wdata (in_cost),
    .raddr ({i_r, l_r}),
    .rdata (bwd_rd)
  );

  // Memo: one best value per (used A, used B, last B)
  assign memo_we = cmd.write;

  bdap_ram #(.WIDTH(MEMO_W), .DEPTH(MEMO_D)) u_memo_ram (
    .clk   (clk),
    .we    (memo_we),
    .waddr ({ua_r, ub_r, l_r}),
    .wdata (best_r),
    .raddr ({ua_succ, ub_succ, j_r}),
    .rdata (memo_rd)
  );

  // Score the candidate read in the previous cycle
  assign bwd_term = root ? '0 : SW'($signed(bwd_rd));
  assign sol = $signed(SW'(memo_rd)) + $signed(SW'({award_r, 1'b0}))
             - SW'($signed(fwd_rd)) - bwd_term;

  // Loop counters and running best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r   <= '0;
      lb_r   <= '0;
      ua_r   <= '0;
      ub_r   <= '0;
      l_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      best_r <= '0;
    end else begin
      if (cmd.init) begin
        la_r   <= la_clamp;
        lb_r   <= lb_clamp;
        ua_r   <= ua_max;
        ub_r   <= ub_max;
        l_r    <= '0;
        i_r    <= '0;
        j_r    <= '0;
        best_r <= '0;
      end
      if (cmd.acc && (sol > $signed(SW'(best_r)))) begin
        best_r <= sol[MEMO_W-1:0];
      end
      if (cmd.adv_pair) begin
        if (CNT_W'(j_r) == CNT_W'(lb_r - 1'b1)) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.write) begin
        best_r <= '0;
        i_r    <= '0;
        j_r    <= '0;
      end
      if (cmd.next_l) begin
        l_r <= l_r + 1'b1;
      end
      // Walk subset pairs in falling order so successors are stored first
      if (cmd.adv_node) begin
        l_r <= '0;
        if (ub_r == '0) begin
          ub_r <= ub_max_cur;
          ua_r <= ua_r - 1'b1;
        end else begin
          ub_r <= ub_r - 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_profit_r <= best_r[PROFIT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_profit = out_profit_r;

  // The empty prefix is never stored in the memo
  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    memo_we |-> !root)
    else $error("memo write at root");

  // A result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output overwritten");

  // Subset walk starts from the full live subsets
  a_subset_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.init) |-> (ua_r == ua_max) && (ub_r == ub_max))
    else $error("subset walk starts out of range");

endmodule

// ===== rtl/bitmask_dp_alternating_pair_path.sv =====
// ----------------------------------------------------------------------------
// bitmask_dp_alternating_pair_path
// Loads forward and backward cost matrices and, on a start item, finds the
// best profit over alternating sequences of distinct (A, B) pairs.
// ----------------------------------------------------------------------------
// Load and ignored items are taken while idle and give no result.
// A start item takes a setup state, then walks every memo entry (subset pair,
// last-B node) bottom up: a node and a write state per entry plus, unless the
// entry is terminal, an issue state per candidate pair and an accumulate state
// per free pair; input stalls meanwhile.
// The result is registered once the empty prefix is scored; the block waits in
// its write state while an earlier result has not been taken.
// Reset (rst_n, synchronous, active low) restores count_a = count_b = 1 and
// pair_award = 250; cost and memo RAMs are not cleared.
module bitmask_dp_alternating_pair_path #(
  parameter int MAX_NODES = bdap_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bdap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] cmd, [5:2] row_index, [9:6] col_index, [25:10] cost_value
  input  logic [bdap_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [19:0] best_profit
  output logic [bdap_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import bdap_pkg::*;

  ctl_cmd_t              cmd;
  ctl_stat_t             stat;
  logic [CMD_W-1:0]      in_cmd;
  logic                  in_fire;
  logic [PROFIT_W-1:0]   profit;

  assign in_cmd  = in_tdata[1:0];
  assign in_fire = in_tvalid && in_tready;

  bdap_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_is_start (in_cmd == CMD_START),
    .in_tready   (in_tready),
    .stat        (stat),
    .cmd         (cmd)
  );

  bdap_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .in_cmd     (in_cmd),
    .in_row     (in_tdata[5:2]),
    .in_col     (in_tdata[9:6]),
    .in_cost    (in_tdata[25:10]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_profit (profit)
  );

  assign out_tdata = {{(OUT_DATA_W - PROFIT_W){1'b0}}, profit};

endmodule

// ===== tb/bdap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdap_checker
// Watches the configuration port and both streams of the pair path block,
// keeps its own copy of the cost matrices and registers, works out the best
// profit for every start item and compares each result item in order.
// ----------------------------------------------------------------------------
module bdap_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bdap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [bdap_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [bdap_pkg::OUT_DATA_W-1:0]   out_tdata,
  output int                                fail_count,
  output int                                profits_pending
);
  import bdap_pkg::*;

  localparam int NODES    = MAX_NODES_DEF;
  localparam int SET_SIZE = 1 << NODES;
  localparam int DEPTH    = SET_SIZE * SET_SIZE * NODES;

  logic signed [COST_W-1:0] fwd_cost [NODES][NODES];
  logic signed [COST_W-1:0] bwd_cost [NODES][NODES];
  int                       memo_best [DEPTH];
  bit                       memo_ok [DEPTH];
  logic [CNT_W-1:0]         count_a, count_b;
  logic [AWARD_W-1:0]       award;
  int                       live_a, live_b;
  logic [OUT_DATA_W-1:0]    profit_q[$];

  // Best profit still to be earned from a prefix of pairs
  function automatic int best_path(int used_a, int used_b, bit has_last, int last);
    int slot;
    int best;
    int sol;
    slot = 0;
    best = 0;
    if ($countones(used_a) == live_a || $countones(used_b) == live_b) return 0;
    if (has_last) begin
      slot = ((used_a * SET_SIZE) + used_b) * NODES + last;
      if (memo_ok[slot]) return memo_best[slot];
    end
    for (int i = 0; i < live_a; i++) begin
      if (used_a[i]) continue;
      for (int j = 0; j < live_b; j++) begin
        if (used_b[j]) continue;
        sol = best_path(used_a | (1 << i), used_b | (1 << j), 1'b1, j);
        sol += 2 * int'(award) - int'(fwd_cost[i][j]);
        if (has_last) sol -= int'(bwd_cost[i][last]);
        if (sol > best) best = sol;
      end
    end
    if (has_last) begin
      memo_best[slot] = best;
      memo_ok[slot]   = 1'b1;
    end
    return best;
  endfunction

  always @(posedge clk) begin
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  row, col;
    logic [OUT_DATA_W-1:0] want;
    int                best;
    if (!rst_n) begin
      count_a    <= COUNT_RESET;
      count_b    <= COUNT_RESET;
      award      <= AWARD_RESET;
      fail_count <= 0;
      profit_q.delete();
      profits_pending <= 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT_A: count_a <= cfg_wdata[CNT_W-1:0];
          CFG_COUNT_B: count_b <= cfg_wdata[CNT_W-1:0];
          CFG_AWARD:   award   <= cfg_wdata[AWARD_W-1:0];
          default: ;
        endcase
      end
      // Apply loads, predict starts
      if (in_tvalid && in_tready) begin
        cmd = in_tdata[1:0];
        row = in_tdata[5:2];
        col = in_tdata[9:6];
        if ((cmd == CMD_LOAD_FWD || cmd == CMD_LOAD_BWD) && row < NODES && col < NODES) begin
          if (cmd == CMD_LOAD_FWD) fwd_cost[row][col] = in_tdata[25:10];
          else bwd_cost[row][col] = in_tdata[25:10];
        end else if (cmd == CMD_START) begin
          for (int k = 0; k < DEPTH; k++) memo_ok[k] = 1'b0;
          live_a = (count_a > NODES) ? NODES : int'(count_a);
          live_b = (count_b > NODES) ? NODES : int'(count_b);
          best = best_path(0, 0, 1'b0, 0);
          profit_q.push_back({{(OUT_DATA_W-PROFIT_W){1'b0}}, best[PROFIT_W-1:0]});
        end
      end
      // Compare each result item with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (profit_q.size() == 0) begin
          $display("%0t: unexpected best_profit item, expected none, actual %0d",
                   $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = profit_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: best_profit mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      profits_pending <= profit_q.size();
    end
  end

endmodule

// ===== tb/bitmask_dp_alternating_pair_path_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmask_dp_alternating_pair_path_tb
// Drives cost loads, ignored items and searches over a series of register
// settings, with random stalls on both streams; the checker scores results.
// ----------------------------------------------------------------------------
module bitmask_dp_alternating_pair_path_tb;
  import bdap_pkg::*;

  localparam int NODES     = MAX_NODES_DEF;
  localparam int LIMIT     = 10_000_000;
  localparam int RAND_ITEMS = 650;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  int                     fail_count;
  int                     profits_pending;
  bit                     no_stall;
  int                     cycles;
  int                     items_sent;
  int                     searches;
  int                     settings;

  bitmask_dp_alternating_pair_path dut (.*);

  bdap_checker u_checker (.*);

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= no_stall ? 1'b1 : ($urandom_range(99) >= 28);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Pack fields, keeping the low bits of each
  function automatic logic [IN_DATA_W-1:0] pack_item(int cmd, int row, int col, int cost);
    return {{(IN_DATA_W-26){1'b0}}, COST_W'(cost), IDX_W'(col), IDX_W'(row), CMD_W'(cmd)};
  endfunction

  // Hand one item over, idling first at random
  task automatic send_item(logic [IN_DATA_W-1:0] data);
    if (!no_stall && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (data[1:0] == CMD_START) searches++;
  endtask

  // Hold off until every result has come and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (profits_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write all registers while idle
  task automatic set_regs(int na, int nb, int aw);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COUNT_A;
    cfg_wdata <= CFG_DATA_W'(na);
    @(posedge clk);
    cfg_index <= CFG_COUNT_B;
    cfg_wdata <= CFG_DATA_W'(nb);
    @(posedge clk);
    cfg_index <= CFG_AWARD;
    cfg_wdata <= CFG_DATA_W'(aw);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_random();
    int pick;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(99);
    cmd  = pick[0] ? CMD_LOAD_BWD : CMD_LOAD_FWD;
    if (pick < 12) send_item(pack_item(CMD_START, $urandom, $urandom, $urandom));
    else if (pick < 17) send_item(pack_item(2'd3, $urandom, $urandom, $urandom));
    else if (pick < 27)
      send_item(pack_item(cmd, $urandom_range(NODES, 15), $urandom, $urandom));
    else
      send_item(pack_item(cmd, $urandom_range(0, NODES - 1),
                          $urandom_range(0, NODES - 1), $urandom));
  endtask

  initial begin
    int na, nb;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    no_stall   = 1'b0;
    cycles     = 0;
    items_sent = 0;
    searches   = 0;
    settings   = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both matrices so no search reads an unwritten cost
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++) begin
        send_item(pack_item(CMD_LOAD_FWD, r, c, $urandom_range(0, 600)));
        send_item(pack_item(CMD_LOAD_BWD, r, c, $urandom_range(0, 600)));
      end

    // Search with reset registers
    send_item(pack_item(CMD_START, 0, 0, 0));
    // Cost extremes and ignored items
    send_item(pack_item(CMD_LOAD_FWD, 0, 0, 16'h8000));
    send_item(pack_item(CMD_LOAD_BWD, 1, 0, 16'h7fff));
    send_item(pack_item(CMD_LOAD_FWD, 15, 15, 16'hffff));
    send_item(pack_item(CMD_LOAD_BWD, 0, NODES, 16'h1234));
    send_item(pack_item(2'd3, 15, 15, 16'hffff));
    send_item(pack_item(CMD_START, 15, 15, 16'hffff));
    send_item(pack_item(CMD_LOAD_FWD, 1, 1, 16'h7fff));

    // Zero counts, award extremes, counts above capacity
    set_regs(0, 3, 1023);
    send_item(pack_item(CMD_START, 0, 0, 0));
    set_regs(3, 0, 0);
    send_item(pack_item(CMD_START, 0, 0, 0));
    set_regs(2, 3, 1023);
    send_item(pack_item(CMD_START, 0, 0, 0));
    set_regs(15, 1, 77);
    send_item(pack_item(CMD_START, 0, 0, 0));
    set_regs(2, 13, 0);
    send_item(pack_item(CMD_START, 0, 0, 0));
    set_regs(NODES, NODES, 1023);
    send_item(pack_item(CMD_START, 0, 0, 0));

    // Random phases, mostly small sizes
    while (items_sent < RAND_ITEMS - 25) begin
      na = ($urandom_range(9) == 0) ? 4 : $urandom_range(0, 3);
      nb = ($urandom_range(9) == 0) ? 4 : $urandom_range(0, 3);
      if (na == 0 && $urandom_range(1)) na = 1;
      set_regs(na, nb, $urandom_range(0, 1023));
      no_stall = (settings % 4 == 2);
      repeat ($urandom_range(40, 60)) send_random();
      no_stall = 1'b0;
    end
    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d items with %0d searches over %0d register settings,",
             items_sent, searches, settings);
    $display("including zero and over-capacity counts and award extremes.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
